/* rtl/rrpm_pkg.sv */
package rrpm_pkg;

   // table depth and the width of the fill count that can hold it
   localparam int MAX_RECTS = 16;
   localparam int COUNT_W   = $clog2(MAX_RECTS + 1);

   // request kinds carried in req_tuser
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_PIXEL = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   // tracker reset values and the color of a hidden pixel
   localparam logic signed [15:0] INT16_MAX_C = 16'sh7FFF;
   localparam logic signed [17:0] INT16_MIN_C = -18'sd32768;
   localparam logic [31:0]        HIDDEN_RGBA = 32'hFF00_0000;
   localparam logic [15:0]        SAT16_MAX   = 16'hFFFF;

   // padded bus widths
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 104;

   // pixel probe that walks down the row of cells
   typedef struct packed {
      logic               valid;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               shown;
   } tok_type;

   // rectangle written into one cell
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
      logic               mark;
   } rect_type;

   // control into the bounds tracker
   typedef struct packed {
      logic add;
      logic clear;
   } bnd_ctl_type;

   // bounds query answer out of the tracker
   typedef struct packed {
      logic               ok;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
   } bnd_res_type;

endpackage

/* rtl/rrpm_cell.sv */
module rrpm_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              active,
   input  logic              wr_en,
   input  rrpm_pkg::rect_type wr_rect,
   input  rrpm_pkg::tok_type  tok_in,
   output rrpm_pkg::tok_type  tok_out
);

   rrpm_pkg::rect_type rect_ff;
   rrpm_pkg::tok_type  tok_ff;
   rrpm_pkg::tok_type  tok_in_c;
   logic signed [17:0] px_e, py_e, rx_e, ry_e, rx_end, ry_end;
   logic               hit;

   // rectangle storage, written once per add
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_ff <= wr_rect;
      end
   end

   // containment test on the probe passing through
   always_comb begin
      px_e   = {{2{tok_in.px[15]}}, tok_in.px};
      py_e   = {{2{tok_in.py[15]}}, tok_in.py};
      rx_e   = {{2{rect_ff.x[15]}}, rect_ff.x};
      ry_e   = {{2{rect_ff.y[15]}}, rect_ff.y};
      rx_end = rx_e + $signed({2'b00, rect_ff.w});
      ry_end = ry_e + $signed({2'b00, rect_ff.h});
      hit    = active && (px_e >= rx_e) && (px_e < rx_end)
                      && (py_e >= ry_e) && (py_e < ry_end);
      tok_in_c = tok_in;
      // a later cell holds a later rectangle, so it overrides
      if (hit) begin
         tok_in_c.shown = rect_ff.mark;
      end
   end

   // hand the probe to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_c.valid;
      end
      tok_ff.px    <= tok_in_c.px;
      tok_ff.py    <= tok_in_c.py;
      tok_ff.shown <= tok_in_c.shown;
   end

   assign tok_out = tok_ff;

endmodule

/* rtl/rrpm_chain.sv */
module rrpm_chain (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rrpm_pkg::COUNT_W-1:0]  count,
   input  logic                          add_en,
   input  rrpm_pkg::rect_type            add_rect,
   input  rrpm_pkg::tok_type             tok_in,
   output rrpm_pkg::tok_type             tok_out
);

   rrpm_pkg::tok_type tok [rrpm_pkg::MAX_RECTS+1];

   assign tok[0] = tok_in;

   // cell i holds table entry i; only entries below the fill count take part
   for (genvar i = 0; i < rrpm_pkg::MAX_RECTS; i++) begin : g_cell
      logic active, wr_en;
      assign active = rrpm_pkg::COUNT_W'(i) < count;
      assign wr_en  = add_en && (count == rrpm_pkg::COUNT_W'(i));

      rrpm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (active),
         .wr_en   (wr_en),
         .wr_rect (add_rect),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign tok_out = tok[rrpm_pkg::MAX_RECTS];

endmodule

/* rtl/rrpm_bounds.sv */
module rrpm_bounds (
   input  logic                  clock,
   input  logic                  reset,
   input  rrpm_pkg::bnd_ctl_type ctl,
   input  logic signed [15:0]    x,
   input  logic signed [15:0]    y,
   input  logic [15:0]           w,
   input  logic [15:0]           h,
   output rrpm_pkg::bnd_res_type res
);

   logic signed [15:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [17:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic signed [17:0] x_end, y_end, min_x_e, min_y_e;
   logic signed [18:0] dx, dy;

   // running min/max over show rectangles
   always_comb begin
      x_end    = {{2{x[15]}}, x} + $signed({2'b00, w});
      y_end    = {{2{y[15]}}, y} + $signed({2'b00, h});
      min_x_in = min_x_ff;
      min_y_in = min_y_ff;
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      if (ctl.clear) begin
         min_x_in = rrpm_pkg::INT16_MAX_C;
         min_y_in = rrpm_pkg::INT16_MAX_C;
         max_x_in = rrpm_pkg::INT16_MIN_C;
         max_y_in = rrpm_pkg::INT16_MIN_C;
      end else if (ctl.add) begin
         if (x < min_x_ff) min_x_in = x;
         if (y < min_y_ff) min_y_in = y;
         if (x_end > max_x_ff) max_x_in = x_end;
         if (y_end > max_y_ff) max_y_in = y_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= rrpm_pkg::INT16_MAX_C;
         min_y_ff <= rrpm_pkg::INT16_MAX_C;
         max_x_ff <= rrpm_pkg::INT16_MIN_C;
         max_y_ff <= rrpm_pkg::INT16_MIN_C;
      end else begin
         min_x_ff <= min_x_in;
         min_y_ff <= min_y_in;
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
      end
   end

   // query answer: box only when both spans are positive, size saturated
   always_comb begin
      min_x_e = {{2{min_x_ff[15]}}, min_x_ff};
      min_y_e = {{2{min_y_ff[15]}}, min_y_ff};
      dx      = {max_x_ff[17], max_x_ff} - {min_x_e[17], min_x_e};
      dy      = {max_y_ff[17], max_y_ff} - {min_y_e[17], min_y_e};
      res.ok  = (min_x_e < max_x_ff) && (min_y_e < max_y_ff);
      res.x   = min_x_ff;
      res.y   = min_y_ff;
      res.w   = (dx > 19'sd65535) ? rrpm_pkg::SAT16_MAX : dx[15:0];
      res.h   = (dy > 19'sd65535) ? rrpm_pkg::SAT16_MAX : dy[15:0];
   end

endmodule

/* rtl/rect_region_pixel_mask_top.sv */
// Channel  Ports       Direction  Contents
// req      req_t*      in         tuser: request kind; tdata: rectangle and pixel fields
// rsp      rsp_t*      out        tdata: pixel, bounds and drop fields
//
// Add, bounds query and clear need no scan: their result goes into the output
// register at acceptance. A pixel item walks the row of MAX_RECTS cells, one
// cell per cycle; its result is registered once it leaves the last cell, and no new item is taken before that.
// Reset empties the table and restores the bounds trackers; no clearing pass.
// One item is at work at a time; a waiting result sits in the output
// register and input is taken again as soon as that register frees.
module rect_region_pixel_mask_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] rect_x, [31:16] rect_y, [47:32] rect_width, [63:48] rect_height,
   // [64] rect_value, [80:65] pixel_x, [96:81] pixel_y, [128:97] pixel_bgra
   input  logic [rrpm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] pixel_rgba, [32] pixel_shown, [33] bounds_valid, [49:34] bounds_x,
   // [65:50] bounds_y, [81:66] bounds_width, [97:82] bounds_height,
   // [98] add_dropped
   output logic [rrpm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                        state_ff, state_in;
   logic [rrpm_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [31:0]                      bgra_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rrpm_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                  accept, full, add_ok, is_add, is_pixel, is_query, is_clear;
   rrpm_pkg::rect_type    add_rect;
   rrpm_pkg::tok_type     tok_in, tok_out;
   rrpm_pkg::bnd_ctl_type bnd_ctl;
   rrpm_pkg::bnd_res_type bnd_res;

   logic [31:0] o_rgba;
   logic        o_shown, o_bvalid, o_drop;
   logic [15:0] o_bx, o_by, o_bw, o_bh;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // request decode
   assign is_add   = req_tuser == rrpm_pkg::REQ_ADD;
   assign is_pixel = req_tuser == rrpm_pkg::REQ_PIXEL;
   assign is_query = req_tuser == rrpm_pkg::REQ_QUERY;
   assign is_clear = req_tuser == rrpm_pkg::REQ_CLEAR;
   assign full     = count_ff == rrpm_pkg::COUNT_W'(rrpm_pkg::MAX_RECTS);
   assign add_ok   = accept && is_add && !full;

   // field unpack
   assign add_rect.x    = req_tdata[15:0];
   assign add_rect.y    = req_tdata[31:16];
   assign add_rect.w    = req_tdata[47:32];
   assign add_rect.h    = req_tdata[63:48];
   assign add_rect.mark = req_tdata[64];

   assign tok_in.valid = accept && is_pixel;
   assign tok_in.px    = req_tdata[80:65];
   assign tok_in.py    = req_tdata[96:81];
   assign tok_in.shown = 1'b0;

   assign bnd_ctl.add   = add_ok && add_rect.mark;
   assign bnd_ctl.clear = accept && is_clear;

   rrpm_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .count    (count_ff),
      .add_en   (add_ok),
      .add_rect (add_rect),
      .tok_in   (tok_in),
      .tok_out  (tok_out)
   );

   rrpm_bounds u_bounds (
      .clock (clock),
      .reset (reset),
      .ctl   (bnd_ctl),
      .x     (add_rect.x),
      .y     (add_rect.y),
      .w     (add_rect.w),
      .h     (add_rect.h),
      .res   (bnd_res)
   );

   // result fields: pixel from the end of the chain, others at acceptance
   always_comb begin
      o_rgba   = '0;
      o_shown  = 1'b0;
      o_bvalid = 1'b0;
      o_bx     = '0;
      o_by     = '0;
      o_bw     = '0;
      o_bh     = '0;
      o_drop   = 1'b0;
      if (tok_out.valid) begin
         o_shown = tok_out.shown;
         o_rgba  = tok_out.shown ? {bgra_ff[31:24], bgra_ff[7:0], bgra_ff[15:8],
                                    bgra_ff[23:16]}
                                 : rrpm_pkg::HIDDEN_RGBA;
      end else if (is_add) begin
         o_drop = full;
      end else if (is_query && (count_ff != '0)) begin
         o_bvalid = 1'b1;
         if (bnd_res.ok) begin
            o_bx = bnd_res.x;
            o_by = bnd_res.y;
            o_bw = bnd_res.w;
            o_bh = bnd_res.h;
         end
      end
      rsp_data_in = {5'b0, o_drop, o_bh, o_bw, o_by, o_bx, o_bvalid, o_shown, o_rgba};
   end

   // control: state, fill count, output register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_pixel) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
               end
               if (add_ok) begin
                  count_in = count_ff + 1'b1;
               end else if (is_clear) begin
                  count_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (tok_out.valid) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept && is_pixel) begin
         bgra_ff <= req_tdata[128:97];
      end
      if ((accept && !is_pixel) || tok_out.valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
